[rtl/ppra_pkg.sv]
// Shared types and constants for the per-peer RSSI accumulator table.
`default_nettype none
package ppra_pkg;

   localparam int ADDR_PORT_BITS = 32;
   localparam int SAMPLE_BITS    = 8;
   localparam int SUM_BITS       = 16;
   localparam int COUNT_BITS     = 8;
   localparam int HELD_BITS      = 7;
   localparam int CMD_BITS       = 2;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_COMMIT = 1'b1
   } state_type;

   // Control broadcast from the sequencer to every cell of the row.
   typedef struct packed {
      logic capture;     // register this cell's address match
      logic shift_down;  // take the entry of the newer neighbor
      logic shift_up;    // take the entry of the older neighbor
      logic accumulate;  // add the sample if this cell matched
   } cell_ctrl_type;

endpackage
`default_nettype wire

[rtl/per_peer_rssi_accumulator_table_unit.sv]
// Top level of the per-peer RSSI accumulator table: command sequencer and row of cells.
`default_nettype none
// The table is a row of TABLE_DEPTH cells, newest entry in cell 0. A transaction is taken
// when start is high and busy is low; in that same cycle every cell compares the request
// address against its stored address and registers the match. The next cycle (busy high)
// commits the command: a hit accumulates in place inside the matching cell while its count
// is below sample_limit, a new peer shifts the row down by one cell and loads cell 0 unless
// the table is full, which sets the overflow flag, a pop shifts the row up by one cell and
// returns what cell 0 held, and a clear empties the table. No transaction is taken while
// busy is high. The result appears on the rsp_ ports for exactly one cycle with rsp_valid
// high, in the cycle after the commit; the receiver cannot hold it off, so it must take it
// then. That result cycle can overlap the next transaction's compare cycle. sample_limit is
// written through csr_wr_en and csr_wr_data and should only change while busy is low. Only
// the low ADDR_BITS bits of the address (at most 32) are compared and stored.
module per_peer_rssi_accumulator_table_unit #(
   parameter int TABLE_DEPTH = 8,
   parameter int ADDR_BITS   = 32
) (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         start,
   output logic                                        busy,
   input  wire  [ppra_pkg::CMD_BITS-1:0]               req_command,
   input  wire  [ppra_pkg::ADDR_PORT_BITS-1:0]         req_peer_addr,
   input  wire  signed [ppra_pkg::SAMPLE_BITS-1:0]     req_rssi_sample,
   input  wire                                         csr_wr_en,
   input  wire  [ppra_pkg::COUNT_BITS-1:0]             csr_wr_data,
   output logic                                        rsp_valid,
   output logic                                        rsp_ok,
   output logic                                        rsp_overflow_flag,
   output logic [ppra_pkg::ADDR_PORT_BITS-1:0]         rsp_entry_addr,
   output logic signed [ppra_pkg::SUM_BITS-1:0]        rsp_entry_sum,
   output logic [ppra_pkg::COUNT_BITS-1:0]             rsp_entry_count,
   output logic [ppra_pkg::HELD_BITS-1:0]              rsp_entries_held
);

   localparam int KEY_BITS  = (ADDR_BITS < ppra_pkg::ADDR_PORT_BITS) ? ADDR_BITS
                                                                      : ppra_pkg::ADDR_PORT_BITS;
   localparam int USED_BITS = $clog2(TABLE_DEPTH + 1);
   localparam logic [USED_BITS-1:0] FULL_COUNT = USED_BITS'(TABLE_DEPTH);

   // Sequencer state and the request held over the commit cycle.
   ppra_pkg::state_type                       state_ff, state_in;
   ppra_pkg::cmd_type                         cmd_ff;
   logic [KEY_BITS-1:0]                       key_ff;
   logic signed [ppra_pkg::SAMPLE_BITS-1:0]   sample_ff;
   logic [USED_BITS-1:0]                      used_ff, used_in;
   logic                                      ovf_ff, ovf_in;
   logic [ppra_pkg::COUNT_BITS-1:0]           limit_ff;

   // Result registers.
   logic                                      rsp_valid_ff;
   logic                                      rsp_ok_ff;
   logic                                      rsp_ovf_ff;
   logic [ppra_pkg::ADDR_PORT_BITS-1:0]       rsp_addr_ff;
   logic signed [ppra_pkg::SUM_BITS-1:0]      rsp_sum_ff;
   logic [ppra_pkg::COUNT_BITS-1:0]           rsp_count_ff;
   logic [ppra_pkg::HELD_BITS-1:0]            rsp_held_ff;

   ppra_pkg::cell_ctrl_type                   cell_ctrl;
   logic                                      accept;
   logic                                      commit;
   logic                                      hit;
   logic                                      full;
   logic                                      empty;
   logic                                      ok;
   logic                                      pop_out;
   logic [KEY_BITS-1:0]                       req_key;
   logic signed [ppra_pkg::SUM_BITS-1:0]      new_sum;
   logic [ppra_pkg::ADDR_PORT_BITS-1:0]       head_addr;
   logic [ppra_pkg::HELD_BITS-1:0]            held_in;

   logic [KEY_BITS-1:0]                       cell_key   [TABLE_DEPTH];
   logic signed [ppra_pkg::SUM_BITS-1:0]      cell_sum   [TABLE_DEPTH];
   logic [ppra_pkg::COUNT_BITS-1:0]           cell_count [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]                    match_vec;

   assign busy    = (state_ff == ppra_pkg::ST_COMMIT);
   assign accept  = start && !busy;
   assign commit  = (state_ff == ppra_pkg::ST_COMMIT);
   assign req_key = req_peer_addr[KEY_BITS-1:0];
   assign hit     = |match_vec;
   assign full    = (used_ff == FULL_COUNT);
   assign empty   = (used_ff == '0);
   assign new_sum = {{(ppra_pkg::SUM_BITS - ppra_pkg::SAMPLE_BITS)
                      {sample_ff[ppra_pkg::SAMPLE_BITS-1]}}, sample_ff};

   // The row of cells. Cell 0 holds the newest entry; a new peer enters there and the
   // older entries move one cell further along. A pop pulls every entry back by one.
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic [KEY_BITS-1:0]                    dn_key, up_key;
      logic signed [ppra_pkg::SUM_BITS-1:0]   dn_sum, up_sum;
      logic [ppra_pkg::COUNT_BITS-1:0]        dn_count, up_count;

      if (g == 0) begin : g_head
         assign dn_key   = key_ff;
         assign dn_sum   = new_sum;
         assign dn_count = ppra_pkg::COUNT_BITS'(1);
      end else begin : g_body
         assign dn_key   = cell_key[g-1];
         assign dn_sum   = cell_sum[g-1];
         assign dn_count = cell_count[g-1];
      end

      if (g == TABLE_DEPTH - 1) begin : g_tail
         assign up_key   = '0;
         assign up_sum   = '0;
         assign up_count = '0;
      end else begin : g_next
         assign up_key   = cell_key[g+1];
         assign up_sum   = cell_sum[g+1];
         assign up_count = cell_count[g+1];
      end

      ppra_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl),
         .in_use   (used_ff > USED_BITS'(g)),
         .req_key  (req_key),
         .sample   (sample_ff),
         .limit    (limit_ff),
         .dn_key   (dn_key),
         .dn_sum   (dn_sum),
         .dn_count (dn_count),
         .up_key   (up_key),
         .up_sum   (up_sum),
         .up_count (up_count),
         .key      (cell_key[g]),
         .sum      (cell_sum[g]),
         .count    (cell_count[g]),
         .match    (match_vec[g])
      );
   end

   // Next state: every accepted transaction enters commit and then returns to idle.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ppra_pkg::ST_IDLE: begin
            if (accept) state_in = ppra_pkg::ST_COMMIT;
         end
         ppra_pkg::ST_COMMIT: begin
            state_in = ppra_pkg::ST_IDLE;
         end
         default: begin
            state_in = ppra_pkg::ST_IDLE;
         end
      endcase
   end

   // Commit decisions: cell controls, new used count and flag, and the result fields.
   always_comb begin
      cell_ctrl         = '0;
      cell_ctrl.capture = accept;
      used_in           = used_ff;
      ovf_in            = ovf_ff;
      ok                = 1'b0;
      pop_out           = 1'b0;
      if (commit) begin
         case (cmd_ff)
            ppra_pkg::CMD_PUSH: begin
               if (hit) begin
                  // Known peer: the matching cell adds the sample unless at its limit.
                  cell_ctrl.accumulate = 1'b1;
                  ok                   = 1'b1;
               end else if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  cell_ctrl.shift_down = 1'b1;
                  used_in              = used_ff + USED_BITS'(1);
                  ok                   = 1'b1;
               end
            end
            ppra_pkg::CMD_POP: begin
               if (!empty) begin
                  cell_ctrl.shift_up = 1'b1;
                  used_in            = used_ff - USED_BITS'(1);
                  ok                 = 1'b1;
                  pop_out            = 1'b1;
               end
            end
            ppra_pkg::CMD_CLEAR: begin
               used_in = '0;
               ovf_in  = 1'b0;
               ok      = 1'b1;
            end
            default: begin
               // The unused command code does nothing and reports failure.
               ok = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      head_addr                = '0;
      head_addr[KEY_BITS-1:0]  = cell_key[0];
      held_in                  = '0;
      held_in[USED_BITS-1:0]   = used_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppra_pkg::ST_IDLE;
         used_ff      <= '0;
         ovf_ff       <= 1'b0;
         limit_ff     <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= commit;
         if (csr_wr_en) limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= ppra_pkg::cmd_type'(req_command);
         key_ff    <= req_key;
         sample_ff <= req_rssi_sample;
      end
      if (commit) begin
         rsp_ok_ff    <= ok;
         rsp_ovf_ff   <= ovf_in;
         rsp_addr_ff  <= pop_out ? head_addr : '0;
         rsp_sum_ff   <= pop_out ? cell_sum[0] : '0;
         rsp_count_ff <= pop_out ? cell_count[0] : '0;
         rsp_held_ff  <= held_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_overflow_flag = rsp_ovf_ff;
   assign rsp_entry_addr    = rsp_addr_ff;
   assign rsp_entry_sum     = rsp_sum_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_entries_held  = rsp_held_ff;

   // Live entries never repeat an address, so at most one cell can match.
   assert property (@(posedge clock) disable iff (reset) $onehot0(match_vec))
      else $error("more than one table cell matched the request address");

   assert property (@(posedge clock) disable iff (reset) used_ff <= FULL_COUNT)
      else $error("used entry count exceeds the table depth");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ppra_pkg::ST_COMMIT))
      else $error("result strobe without a preceding commit cycle");

   assert property (@(posedge clock) disable iff (reset)
      (commit && cmd_ff == ppra_pkg::CMD_POP && !empty) |=> used_ff == $past(used_ff) - USED_BITS'(1))
      else $error("pop did not remove exactly one entry");

   assert property (@(posedge clock) disable iff (reset)
      $rose(ovf_ff) |-> $past(commit && cmd_ff == ppra_pkg::CMD_PUSH && full && !hit))
      else $error("overflow flag set other than by a push to a full table");

endmodule
`default_nettype wire

[rtl/ppra_cell.sv]
// One table cell: holds one peer entry, compares its address and shifts with its neighbors.
`default_nettype none
module ppra_cell #(
   parameter int KEY_BITS = 32
) (
   input  wire                                           clock,
   input  wire                                           reset,
   input  ppra_pkg::cell_ctrl_type                        ctrl,
   input  wire                                           in_use,
   input  wire  [KEY_BITS-1:0]                           req_key,
   input  wire  signed [ppra_pkg::SAMPLE_BITS-1:0]       sample,
   input  wire  [ppra_pkg::COUNT_BITS-1:0]               limit,
   input  wire  [KEY_BITS-1:0]                           dn_key,
   input  wire  signed [ppra_pkg::SUM_BITS-1:0]          dn_sum,
   input  wire  [ppra_pkg::COUNT_BITS-1:0]               dn_count,
   input  wire  [KEY_BITS-1:0]                           up_key,
   input  wire  signed [ppra_pkg::SUM_BITS-1:0]          up_sum,
   input  wire  [ppra_pkg::COUNT_BITS-1:0]               up_count,
   output logic [KEY_BITS-1:0]                           key,
   output logic signed [ppra_pkg::SUM_BITS-1:0]          sum,
   output logic [ppra_pkg::COUNT_BITS-1:0]               count,
   output logic                                          match
);

   logic [KEY_BITS-1:0]                    key_ff;
   logic signed [ppra_pkg::SUM_BITS-1:0]   sum_ff;
   logic [ppra_pkg::COUNT_BITS-1:0]        count_ff;
   logic                                   match_ff;
   logic signed [ppra_pkg::SUM_BITS-1:0]   sample_ext;

   assign sample_ext = {{(ppra_pkg::SUM_BITS - ppra_pkg::SAMPLE_BITS){sample[ppra_pkg::SAMPLE_BITS-1]}},
                        sample};

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else if (ctrl.capture) begin
         match_ff <= in_use && (key_ff == req_key);
      end
   end

   // Entry payload carries no reset; the used count says which cells are live.
   always_ff @(posedge clock) begin
      if (ctrl.shift_down) begin
         key_ff   <= dn_key;
         sum_ff   <= dn_sum;
         count_ff <= dn_count;
      end else if (ctrl.shift_up) begin
         key_ff   <= up_key;
         sum_ff   <= up_sum;
         count_ff <= up_count;
      end else if (ctrl.accumulate && match_ff && (count_ff < limit)) begin
         sum_ff   <= sum_ff + sample_ext;
         count_ff <= count_ff + ppra_pkg::COUNT_BITS'(1);
      end
   end

   assign key   = key_ff;
   assign sum   = sum_ff;
   assign count = count_ff;
   assign match = match_ff;

endmodule
`default_nettype wire

[dv/rssi_table_checker.sv]
// Checker for the per-peer RSSI accumulator table: tracks the table and compares every reply.
module rssi_table_checker #(
   parameter int TABLE_DEPTH = 8
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      start,
   input  wire                                      busy,
   input  wire [ppra_pkg::CMD_BITS-1:0]             req_command,
   input  wire [ppra_pkg::ADDR_PORT_BITS-1:0]       req_peer_addr,
   input  wire [ppra_pkg::SAMPLE_BITS-1:0]          req_rssi_sample,
   input  wire                                      csr_wr_en,
   input  wire [ppra_pkg::COUNT_BITS-1:0]           csr_wr_data,
   input  wire                                      rsp_valid,
   input  wire                                      rsp_ok,
   input  wire                                      rsp_overflow_flag,
   input  wire [ppra_pkg::ADDR_PORT_BITS-1:0]       rsp_entry_addr,
   input  wire [ppra_pkg::SUM_BITS-1:0]             rsp_entry_sum,
   input  wire [ppra_pkg::COUNT_BITS-1:0]           rsp_entry_count,
   input  wire [ppra_pkg::HELD_BITS-1:0]            rsp_entries_held,
   output int                                       mismatch_count,
   output int                                       replies_pending
);

   typedef struct packed {
      logic                                  ok;
      logic                                  overflow;
      logic [ppra_pkg::ADDR_PORT_BITS-1:0]   addr;
      logic [ppra_pkg::SUM_BITS-1:0]         sum;
      logic [ppra_pkg::COUNT_BITS-1:0]       count;
      logic [ppra_pkg::HELD_BITS-1:0]        held;
   } table_reply_type;

   logic [ppra_pkg::ADDR_PORT_BITS-1:0] peer_addr_row    [TABLE_DEPTH];
   logic [ppra_pkg::SUM_BITS-1:0]       rssi_sum_row     [TABLE_DEPTH];
   logic [ppra_pkg::COUNT_BITS-1:0]     sample_count_row [TABLE_DEPTH];
   int                                  entries_in_use;
   logic                                overflow_latched;
   logic [ppra_pkg::COUNT_BITS-1:0]     count_limit;
   table_reply_type                     awaited_replies [$];
   int                                  fail_total = 0;

   // Applies one command to the tracked table and returns the reply it must produce.
   task automatic apply_table_command(input logic [ppra_pkg::CMD_BITS-1:0] cmd,
                                      input logic [ppra_pkg::ADDR_PORT_BITS-1:0] addr,
                                      input logic [ppra_pkg::SAMPLE_BITS-1:0] sample,
                                      output table_reply_type reply);
      int hit;
      int i;
      reply = '0;
      hit = -1;
      if (cmd == ppra_pkg::CMD_PUSH) begin
         for (i = 0; i < entries_in_use; i++)
            if (hit < 0 && peer_addr_row[i] == addr) hit = i;
         if (hit >= 0) begin
            if (sample_count_row[hit] < count_limit) begin
               rssi_sum_row[hit]     = rssi_sum_row[hit] + {{8{sample[7]}}, sample};
               sample_count_row[hit] = sample_count_row[hit] + 8'd1;
            end
            reply.ok = 1'b1;
         end else if (entries_in_use >= TABLE_DEPTH) begin
            overflow_latched = 1'b1;
         end else begin
            peer_addr_row[entries_in_use]    = addr;
            rssi_sum_row[entries_in_use]     = {{8{sample[7]}}, sample};
            sample_count_row[entries_in_use] = 8'd1;
            entries_in_use++;
            reply.ok = 1'b1;
         end
      end else if (cmd == ppra_pkg::CMD_POP) begin
         if (entries_in_use > 0) begin
            entries_in_use--;
            reply.ok    = 1'b1;
            reply.addr  = peer_addr_row[entries_in_use];
            reply.sum   = rssi_sum_row[entries_in_use];
            reply.count = sample_count_row[entries_in_use];
         end
      end else if (cmd == ppra_pkg::CMD_CLEAR) begin
         entries_in_use   = 0;
         overflow_latched = 1'b0;
         reply.ok         = 1'b1;
      end
      reply.overflow = overflow_latched;
      reply.held     = ppra_pkg::HELD_BITS'(entries_in_use);
   endtask

   task automatic note_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
      if (want !== got) begin
         fail_total++;
         if (fail_total <= 10)
            $display("%0t: reply %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch_channels
      table_reply_type want;
      table_reply_type got;
      if (reset) begin
         entries_in_use   = 0;
         overflow_latched = 1'b0;
         count_limit      = 8'd255;
         awaited_replies.delete();
      end else begin
         if (rsp_valid) begin
            got = {rsp_ok, rsp_overflow_flag, rsp_entry_addr, rsp_entry_sum,
                   rsp_entry_count, rsp_entries_held};
            if (awaited_replies.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("%0t: reply with no transaction outstanding", $time);
            end else begin
               want = awaited_replies.pop_front();
               note_field("ok", want.ok, got.ok);
               note_field("overflow_flag", want.overflow, got.overflow);
               note_field("entry_addr", want.addr, got.addr);
               note_field("entry_sum", want.sum, got.sum);
               note_field("entry_count", want.count, got.count);
               note_field("entries_held", want.held, got.held);
            end
         end
         if (start && !busy) begin
            apply_table_command(req_command, req_peer_addr, req_rssi_sample, want);
            awaited_replies.push_back(want);
         end
         if (csr_wr_en) count_limit = csr_wr_data;
      end
      mismatch_count  <= fail_total;
      replies_pending <= awaited_replies.size();
   end

endmodule

[dv/per_peer_rssi_accumulator_table_unit_tb.sv]
// Testbench top for the per-peer RSSI accumulator table: stimulus, clock, reset and verdict.
module per_peer_rssi_accumulator_table_unit_tb;

   // Command code that the block must treat as a no-operation.
   localparam logic [ppra_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   localparam int PEER_POOL_SIZE = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [ppra_pkg::CMD_BITS-1:0]       req_command     = ppra_pkg::CMD_PUSH;
   logic [ppra_pkg::ADDR_PORT_BITS-1:0] req_peer_addr   = '0;
   logic [ppra_pkg::SAMPLE_BITS-1:0]    req_rssi_sample = '0;
   logic        csr_wr_en = 1'b0;
   logic [ppra_pkg::COUNT_BITS-1:0]     csr_wr_data = '0;

   logic        busy;
   logic        rsp_valid;
   logic        rsp_ok;
   logic        rsp_overflow_flag;
   logic [ppra_pkg::ADDR_PORT_BITS-1:0] rsp_entry_addr;
   logic signed [ppra_pkg::SUM_BITS-1:0] rsp_entry_sum;
   logic [ppra_pkg::COUNT_BITS-1:0]     rsp_entry_count;
   logic [ppra_pkg::HELD_BITS-1:0]      rsp_entries_held;

   int          mismatch_count;
   int          replies_pending;

   // When set, the sender issues transactions back to back with no gaps at all.
   bit          quiet_stretch;
   logic [ppra_pkg::ADDR_PORT_BITS-1:0] peer_pool [PEER_POOL_SIZE];

   always #10 clock = ~clock;

   per_peer_rssi_accumulator_table_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_peer_addr     (req_peer_addr),
      .req_rssi_sample   (req_rssi_sample),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ok            (rsp_ok),
      .rsp_overflow_flag (rsp_overflow_flag),
      .rsp_entry_addr    (rsp_entry_addr),
      .rsp_entry_sum     (rsp_entry_sum),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_entries_held  (rsp_entries_held)
   );

   // The checker sees the same pins as the block and reports back how many replies
   // are still outstanding and how many mismatches it has found so far.
   rssi_table_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_peer_addr     (req_peer_addr),
      .req_rssi_sample   (req_rssi_sample),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ok            (rsp_ok),
      .rsp_overflow_flag (rsp_overflow_flag),
      .rsp_entry_addr    (rsp_entry_addr),
      .rsp_entry_sum     (rsp_entry_sum),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_entries_held  (rsp_entries_held),
      .mismatch_count    (mismatch_count),
      .replies_pending   (replies_pending)
   );

   // Most gaps are zero or a few cycles; now and then a long one lets the block sit idle.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_stretch || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Drives one transaction on the falling edge and holds it until the block takes it.
   // Start stays high when the next transaction follows without a gap, so it is never
   // lowered and raised within the same time step.
   task automatic issue(input logic [ppra_pkg::CMD_BITS-1:0] cmd,
                        input logic [ppra_pkg::ADDR_PORT_BITS-1:0] addr,
                        input logic [ppra_pkg::SAMPLE_BITS-1:0] sample);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start           <= 1'b1;
      req_command     <= cmd;
      req_peer_addr   <= addr;
      req_rssi_sample <= sample;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Stops sending and waits until the checker has seen every reply it expects.
   // Every transaction produces exactly one reply, so an empty queue means idle.
   task automatic drain_replies();
      @(negedge clock);
      start <= 1'b0;
      do @(posedge clock); while (replies_pending != 0);
   endtask

   // The limit register is only touched while the table is idle.
   task automatic write_sample_limit(input logic [ppra_pkg::COUNT_BITS-1:0] limit);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Refills the peer pool; a small pool means repeated peers, so hits, full tables
   // and counts that run into the limit all show up often.
   task automatic refill_peer_pool();
      peer_pool[0] = '0;
      peer_pool[1] = '1;
      for (int i = 2; i < PEER_POOL_SIZE; i++) peer_pool[i] = $urandom;
   endtask

   function automatic logic [ppra_pkg::SAMPLE_BITS-1:0] pick_sample();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 8'h80;
      if (roll == 1) return 8'h7f;
      return ppra_pkg::SAMPLE_BITS'($urandom_range(0, 255));
   endfunction

   // One phase of random traffic: mostly pushes to pooled peers, plus pops, clears,
   // the odd unused command, a few stray addresses, and once in a while a full stop
   // until the block has answered everything.
   task automatic random_phase(input int item_total);
      int roll;
      logic [ppra_pkg::ADDR_PORT_BITS-1:0] addr;
      refill_peer_pool();
      for (int n = 0; n < item_total; n++) begin
         if (n % 20 == 0) quiet_stretch = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 49) == 0) drain_replies();
         roll = $urandom_range(0, 99);
         addr = ($urandom_range(0, 9) == 0) ? $urandom
                                            : peer_pool[$urandom_range(0, PEER_POOL_SIZE - 1)];
         if (roll < 73) issue(ppra_pkg::CMD_PUSH, addr, pick_sample());
         else if (roll < 93) issue(ppra_pkg::CMD_POP, $urandom, pick_sample());
         else if (roll < 97) issue(ppra_pkg::CMD_CLEAR, $urandom, pick_sample());
         else issue(CMD_UNUSED, $urandom, pick_sample());
      end
      drain_replies();
   endtask

   initial begin
      quiet_stretch = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening at the reset limit of 255: empty pop, unused command, address
      // extremes, a hit, filling the table, a new peer on a full table, a hit while full,
      // pops that return the newest entries, a clear, and a pop on the emptied table.
      issue(ppra_pkg::CMD_POP, 32'h0, 8'h00);
      issue(CMD_UNUSED, 32'hffff_ffff, 8'hff);
      issue(ppra_pkg::CMD_PUSH, 32'h0000_0000, 8'h80);
      issue(ppra_pkg::CMD_PUSH, 32'hffff_ffff, 8'h7f);
      issue(ppra_pkg::CMD_PUSH, 32'h0000_0000, 8'h80);
      issue(ppra_pkg::CMD_PUSH, 32'ha5a5_a5a5, 8'h01);
      issue(ppra_pkg::CMD_PUSH, 32'h5a5a_5a5a, 8'hff);
      issue(ppra_pkg::CMD_PUSH, 32'h0000_0001, 8'h00);
      issue(ppra_pkg::CMD_PUSH, 32'h8000_0000, 8'h40);
      issue(ppra_pkg::CMD_PUSH, 32'h7fff_fffe, 8'hc0);
      issue(ppra_pkg::CMD_PUSH, 32'h1234_5678, 8'h55);
      issue(ppra_pkg::CMD_PUSH, 32'h0f0f_0f0f, 8'haa);
      issue(ppra_pkg::CMD_PUSH, 32'hffff_ffff, 8'h01);
      issue(CMD_UNUSED, 32'h0, 8'h00);
      issue(ppra_pkg::CMD_POP, 32'h0, 8'h00);
      issue(ppra_pkg::CMD_POP, 32'h0, 8'h00);
      issue(ppra_pkg::CMD_PUSH, 32'h0f0f_0f0f, 8'hfb);
      issue(ppra_pkg::CMD_POP, 32'h0, 8'h00);
      issue(ppra_pkg::CMD_CLEAR, 32'h0, 8'h00);
      issue(ppra_pkg::CMD_POP, 32'h0, 8'h00);
      issue(ppra_pkg::CMD_PUSH, 32'h8000_0000, 8'h00);
      issue(ppra_pkg::CMD_POP, 32'h0, 8'h00);
      drain_replies();

      // Saturate one peer at the largest limit: the count climbs to 255, the sum to 32385, and
      // the last samples are dropped, then the pop shows the final sum and count.
      write_sample_limit(8'd255);
      quiet_stretch = 1'b1;
      issue(ppra_pkg::CMD_CLEAR, 32'h0, 8'h00);
      repeat (257) issue(ppra_pkg::CMD_PUSH, 32'hc3c3_3c3c, 8'h7f);
      issue(ppra_pkg::CMD_POP, 32'h0, 8'h00);
      quiet_stretch = 1'b0;
      drain_replies();

      // Random traffic under several limits, the extremes among them. A limit of zero
      // still lets a new peer start at count one but drops every later sample.
      write_sample_limit(8'd1);
      random_phase(55);
      write_sample_limit(8'd0);
      random_phase(55);
      write_sample_limit(8'd3);
      random_phase(55);
      write_sample_limit(ppra_pkg::COUNT_BITS'($urandom_range(1, 254)));
      random_phase(55);
      write_sample_limit(8'd255);
      random_phase(55);

      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("per_peer_rssi_accumulator_table_unit_tb passed");
      end else begin
         $display("per_peer_rssi_accumulator_table_unit_tb failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, including every long gap.
   initial begin
      #6_000_000;
      $display("per_peer_rssi_accumulator_table_unit_tb failed");
      $finish;
   end

endmodule
